### hw/rtl/jcmp_pkg.sv
// shared types, constants and register codes for the joystick cursor map pager
package jcmp_pkg;

    // defaults for the top-level parameters
    localparam int VIEW_WIDTH_DEF  = 420;
    localparam int VIEW_HEIGHT_DEF = 320;
    localparam int IMAGE_SIZE_DEF  = 2048;
    localparam int STEP_DIV_DEF    = 128;

    // fixed field widths
    localparam int SAMPLE_W = 10;
    localparam int CURSOR_W = 9;
    localparam int WINDOW_W = 11;
    localparam int MARGIN_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // signed working width for cursor and window arithmetic
    localparam int CALC_W = 13;
    // signed step width, magnitude up to 1024
    localparam int STEP_W = 12;

    // reciprocal shift: exact floor for any 10-bit dividend and divisor up to 512
    localparam int RECIP_SHIFT = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BOUND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_BOUND    = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] upper_threshold;
        logic [SAMPLE_W-1:0] lower_threshold;
        logic [MARGIN_W-1:0] edge_margin;
        logic [CURSOR_W-1:0] right_bound;
        logic [CURSOR_W-1:0] bottom_bound;
    } t_cfg;

endpackage

### hw/rtl/jcmp_axis_step.sv
// dead band and scaled step for one joystick axis
module jcmp_axis_step #(
    parameter int STEP_DIV = jcmp_pkg::STEP_DIV_DEF
) (
    input  logic [jcmp_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic [jcmp_pkg::SAMPLE_W-1:0]      i_upper,
    input  logic [jcmp_pkg::SAMPLE_W-1:0]      i_lower,
    output logic signed [jcmp_pkg::STEP_W-1:0] o_step
);

    localparam int SW = jcmp_pkg::SAMPLE_W;
    localparam int RECIP_W = jcmp_pkg::RECIP_SHIFT + 1;
    localparam int PROD_W = SW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << jcmp_pkg::RECIP_SHIFT) + STEP_DIV - 1) / STEP_DIV);

    logic              above;
    logic              below;
    logic [SW-1:0]     excess;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]     quot;
    logic [jcmp_pkg::STEP_W-1:0] mag;

    // upper test wins when the band is inverted
    assign above  = i_sample > i_upper;
    assign below  = !above && (i_sample < i_lower);
    assign excess = above ? (i_sample - i_upper) : (i_lower - i_sample);

    // divide by reciprocal multiply
    assign prod = PROD_W'(excess) * PROD_W'(RECIP);
    assign quot = prod[jcmp_pkg::RECIP_SHIFT +: SW];
    assign mag  = jcmp_pkg::STEP_W'(quot) + jcmp_pkg::STEP_W'(1);

    always_comb begin
        if (above) begin
            o_step = $signed(mag);
        end else if (below) begin
            o_step = -$signed(mag);
        end else begin
            o_step = '0;
        end
    end

endmodule

### hw/rtl/jcmp_track.sv
// cursor move, edge hold and window paging for one item
module jcmp_track #(
    parameter int VIEW_WIDTH  = jcmp_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = jcmp_pkg::VIEW_HEIGHT_DEF,
    parameter int IMAGE_SIZE  = jcmp_pkg::IMAGE_SIZE_DEF
) (
    input  jcmp_pkg::t_cfg                     i_cfg,
    input  logic signed [jcmp_pkg::STEP_W-1:0] i_step_x,
    input  logic signed [jcmp_pkg::STEP_W-1:0] i_step_y,
    input  logic [jcmp_pkg::CURSOR_W-1:0]      i_cur_x,
    input  logic [jcmp_pkg::CURSOR_W-1:0]      i_cur_y,
    input  logic [jcmp_pkg::WINDOW_W-1:0]      i_win_x,
    input  logic [jcmp_pkg::WINDOW_W-1:0]      i_win_y,
    output logic [jcmp_pkg::CURSOR_W-1:0]      o_cur_x,
    output logic [jcmp_pkg::CURSOR_W-1:0]      o_cur_y,
    output logic [jcmp_pkg::WINDOW_W-1:0]      o_win_x,
    output logic [jcmp_pkg::WINDOW_W-1:0]      o_win_y,
    output logic                               o_moved,
    output logic                               o_paged
);

    localparam int CW = jcmp_pkg::CALC_W;
    localparam logic signed [CW-1:0] WX_MAX = CW'(IMAGE_SIZE - VIEW_WIDTH);
    localparam logic signed [CW-1:0] WY_MAX = CW'(IMAGE_SIZE - VIEW_HEIGHT);
    localparam logic signed [CW-1:0] VW = CW'(VIEW_WIDTH);
    localparam logic signed [CW-1:0] VH = CW'(VIEW_HEIGHT);
    localparam logic [jcmp_pkg::CURSOR_W-1:0] CX_HOME = jcmp_pkg::CURSOR_W'(VIEW_WIDTH / 2);
    localparam logic [jcmp_pkg::CURSOR_W-1:0] CY_HOME = jcmp_pkg::CURSOR_W'(VIEW_HEIGHT / 2);

    logic signed [CW-1:0] margin;
    logic signed [CW-1:0] rb;
    logic signed [CW-1:0] bb;
    logic signed [CW-1:0] owx;
    logic signed [CW-1:0] owy;
    logic signed [CW-1:0] cx_raw;
    logic signed [CW-1:0] cy_raw;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] wx_pg;
    logic signed [CW-1:0] wy_pg;
    logic signed [CW-1:0] wx;
    logic signed [CW-1:0] wy;
    logic                 out_l, out_r, out_t, out_b, page;

    assign margin = $signed({{(CW - jcmp_pkg::MARGIN_W){1'b0}}, i_cfg.edge_margin});
    assign rb     = $signed({{(CW - jcmp_pkg::CURSOR_W){1'b0}}, i_cfg.right_bound});
    assign bb     = $signed({{(CW - jcmp_pkg::CURSOR_W){1'b0}}, i_cfg.bottom_bound});
    assign owx    = $signed({{(CW - jcmp_pkg::WINDOW_W){1'b0}}, i_win_x});
    assign owy    = $signed({{(CW - jcmp_pkg::WINDOW_W){1'b0}}, i_win_y});

    // x step is inverted
    assign cx_raw = $signed({{(CW - jcmp_pkg::CURSOR_W){1'b0}}, i_cur_x})
                  - $signed({{(CW - jcmp_pkg::STEP_W){i_step_x[jcmp_pkg::STEP_W-1]}}, i_step_x});
    assign cy_raw = $signed({{(CW - jcmp_pkg::CURSOR_W){1'b0}}, i_cur_y})
                  + $signed({{(CW - jcmp_pkg::STEP_W){i_step_y[jcmp_pkg::STEP_W-1]}}, i_step_y});

    always_comb begin
        cx = cx_raw;
        cy = cy_raw;
        // hold the cursor where the window touches an image edge
        if (owx == '0 && cx < margin) cx = margin;
        if (owx == WX_MAX && cx > rb) cx = rb;
        if (owy == '0 && cy < margin) cy = margin;
        if (owy == WY_MAX && cy > bb) cy = bb;

        out_l = cx < margin;
        out_r = cx > rb;
        out_t = cy < margin;
        out_b = cy > bb;
        page  = out_l || out_r || out_t || out_b;

        wx_pg = owx;
        wy_pg = owy;
        if (out_l) wx_pg = wx_pg - VW;
        if (out_r) wx_pg = wx_pg + VW;
        if (out_t) wy_pg = wy_pg - VH;
        if (out_b) wy_pg = wy_pg + VH;

        wx = owx;
        wy = owy;
        if (page) begin
            if (wx_pg < 0) wx = '0;
            else if (wx_pg > WX_MAX) wx = WX_MAX;
            else wx = wx_pg;
            if (wy_pg < 0) wy = '0;
            else if (wy_pg > WY_MAX) wy = WY_MAX;
            else wy = wy_pg;
        end

        if (page) begin
            o_cur_x = CX_HOME;
            o_cur_y = CY_HOME;
        end else begin
            o_cur_x = cx[jcmp_pkg::CURSOR_W-1:0];
            o_cur_y = cy[jcmp_pkg::CURSOR_W-1:0];
        end
        o_win_x = wx[jcmp_pkg::WINDOW_W-1:0];
        o_win_y = wy[jcmp_pkg::WINDOW_W-1:0];
    end

    assign o_moved = (o_cur_x != i_cur_x) || (o_cur_y != i_cur_y);
    assign o_paged = (o_win_x != i_win_x) || (o_win_y != i_win_y);

endmodule

### hw/rtl/joystick_cursor_map_pager_core.sv
// top level of the joystick cursor map pager
//
// input channel: i_in_valid / o_in_stall carry one joystick sample pair
// (i_joy_x, i_joy_y); an item is taken on a clock edge with valid high and
// stall low. output channel: o_out_valid / i_out_stall carry one result item
// per input item: new and old cursor, window origin, moved and paged flags.
// each item lands in an input register, goes through one short pass of
// combinational logic (two reciprocal multiplies, adds and compares) and is
// caught in the output register, from which o_out_valid offers the result;
// one item per cycle is sustained while the output is not stalled.
// cursor and window state advance at the moment an item moves from the input
// register to the output register, so the next item sees it at once.
// a stall on the output holds the result; the input register still takes one
// more item, then o_in_stall rises until the result is taken.
// configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data) that
// the user must write only while no item is in flight; the block does not
// enforce this. unknown indexes are ignored.
// synchronous active-low reset restores register defaults, centres the
// cursor in the view and the window in the image, and empties both stages.
module joystick_cursor_map_pager_core #(
    parameter int VIEW_WIDTH  = jcmp_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = jcmp_pkg::VIEW_HEIGHT_DEF,
    parameter int IMAGE_SIZE  = jcmp_pkg::IMAGE_SIZE_DEF,
    parameter int STEP_DIV    = jcmp_pkg::STEP_DIV_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [jcmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jcmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [jcmp_pkg::SAMPLE_W-1:0]     i_joy_x,
    input  logic [jcmp_pkg::SAMPLE_W-1:0]     i_joy_y,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [jcmp_pkg::CURSOR_W-1:0]     o_cursor_x,
    output logic [jcmp_pkg::CURSOR_W-1:0]     o_cursor_y,
    output logic [jcmp_pkg::CURSOR_W-1:0]     o_old_cursor_x,
    output logic [jcmp_pkg::CURSOR_W-1:0]     o_old_cursor_y,
    output logic [jcmp_pkg::WINDOW_W-1:0]     o_window_x,
    output logic [jcmp_pkg::WINDOW_W-1:0]     o_window_y,
    output logic                              o_moved,
    output logic                              o_paged
);

    localparam int SW = jcmp_pkg::SAMPLE_W;
    localparam int CUW = jcmp_pkg::CURSOR_W;
    localparam int WW = jcmp_pkg::WINDOW_W;
    localparam logic [CUW-1:0] CX_RST = CUW'(VIEW_WIDTH / 2);
    localparam logic [CUW-1:0] CY_RST = CUW'(VIEW_HEIGHT / 2);
    localparam logic [WW-1:0]  WX_RST = WW'(IMAGE_SIZE / 2 - VIEW_WIDTH / 2);
    localparam logic [WW-1:0]  WY_RST = WW'(IMAGE_SIZE / 2 - VIEW_HEIGHT / 2);
    localparam logic [WW-1:0]  WX_MAX = WW'(IMAGE_SIZE - VIEW_WIDTH);
    localparam logic [WW-1:0]  WY_MAX = WW'(IMAGE_SIZE - VIEW_HEIGHT);

    // configuration registers
    jcmp_pkg::t_cfg r_cfg;

    // input stage
    logic          r_in_valid;
    logic [SW-1:0] r_joy_x;
    logic [SW-1:0] r_joy_y;

    // cursor and window state
    logic [CUW-1:0] r_cur_x;
    logic [CUW-1:0] r_cur_y;
    logic [WW-1:0]  r_win_x;
    logic [WW-1:0]  r_win_y;

    // output stage
    logic           r_out_valid;
    logic [CUW-1:0] r_out_cx;
    logic [CUW-1:0] r_out_cy;
    logic [CUW-1:0] r_out_ox;
    logic [CUW-1:0] r_out_oy;
    logic [WW-1:0]  r_out_wx;
    logic [WW-1:0]  r_out_wy;
    logic           r_out_moved;
    logic           r_out_paged;

    logic out_free;
    logic advance;
    logic in_take;

    logic signed [jcmp_pkg::STEP_W-1:0] step_x;
    logic signed [jcmp_pkg::STEP_W-1:0] step_y;
    logic [CUW-1:0] n_cur_x;
    logic [CUW-1:0] n_cur_y;
    logic [WW-1:0]  n_win_x;
    logic [WW-1:0]  n_win_y;
    logic           n_moved;
    logic           n_paged;

    // output register frees up when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_threshold <= 10'd532;
            r_cfg.lower_threshold <= 10'd492;
            r_cfg.edge_margin     <= 6'd4;
            r_cfg.right_bound     <= 9'd415;
            r_cfg.bottom_bound    <= 9'd315;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jcmp_pkg::CFG_UPPER_THRESHOLD: begin
                    r_cfg.upper_threshold <= i_cfg_data;
                end
                jcmp_pkg::CFG_LOWER_THRESHOLD: begin
                    r_cfg.lower_threshold <= i_cfg_data;
                end
                jcmp_pkg::CFG_EDGE_MARGIN: begin
                    r_cfg.edge_margin <= i_cfg_data[jcmp_pkg::MARGIN_W-1:0];
                end
                jcmp_pkg::CFG_RIGHT_BOUND: begin
                    r_cfg.right_bound <= i_cfg_data[CUW-1:0];
                end
                jcmp_pkg::CFG_BOTTOM_BOUND: begin
                    r_cfg.bottom_bound <= i_cfg_data[CUW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_joy_x <= i_joy_x;
            r_joy_y <= i_joy_y;
        end
    end

    jcmp_axis_step #(
        .STEP_DIV (STEP_DIV)
    ) u_step_x (
        .i_sample (r_joy_x),
        .i_upper  (r_cfg.upper_threshold),
        .i_lower  (r_cfg.lower_threshold),
        .o_step   (step_x)
    );

    jcmp_axis_step #(
        .STEP_DIV (STEP_DIV)
    ) u_step_y (
        .i_sample (r_joy_y),
        .i_upper  (r_cfg.upper_threshold),
        .i_lower  (r_cfg.lower_threshold),
        .o_step   (step_y)
    );

    jcmp_track #(
        .VIEW_WIDTH  (VIEW_WIDTH),
        .VIEW_HEIGHT (VIEW_HEIGHT),
        .IMAGE_SIZE  (IMAGE_SIZE)
    ) u_track (
        .i_cfg    (r_cfg),
        .i_step_x (step_x),
        .i_step_y (step_y),
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .i_win_x  (r_win_x),
        .i_win_y  (r_win_y),
        .o_cur_x  (n_cur_x),
        .o_cur_y  (n_cur_y),
        .o_win_x  (n_win_x),
        .o_win_y  (n_win_y),
        .o_moved  (n_moved),
        .o_paged  (n_paged)
    );

    // state moves together with the item into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= CX_RST;
            r_cur_y <= CY_RST;
            r_win_x <= WX_RST;
            r_win_y <= WY_RST;
        end else if (advance) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_win_x <= n_win_x;
            r_win_y <= n_win_y;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_cx    <= n_cur_x;
            r_out_cy    <= n_cur_y;
            r_out_ox    <= r_cur_x;
            r_out_oy    <= r_cur_y;
            r_out_wx    <= n_win_x;
            r_out_wy    <= n_win_y;
            r_out_moved <= n_moved;
            r_out_paged <= n_paged;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_x     = r_out_cx;
    assign o_cursor_y     = r_out_cy;
    assign o_old_cursor_x = r_out_ox;
    assign o_old_cursor_y = r_out_oy;
    assign o_window_x     = r_out_wx;
    assign o_window_y     = r_out_wy;
    assign o_moved        = r_out_moved;
    assign o_paged        = r_out_paged;

    // the held result always mirrors the live state
    a_state_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_cur_x == r_out_cx && r_cur_y == r_out_cy &&
                         r_win_x == r_out_wx && r_win_y == r_out_wy))
        else $error("state and output register disagree");

    // a page always re-centres the cursor
    a_page_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_paged) |-> (r_out_cx == CX_RST && r_out_cy == CY_RST))
        else $error("paged without re-centring the cursor");

    // window stays inside the image
    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win_x <= WX_MAX && r_win_y <= WY_MAX))
        else $error("window origin outside the image");

    // input stalls only behind a stalled, full output stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    // a stalled result keeps its state until it is taken
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_cur_x) && $stable(r_win_x) &&
                                          $stable(r_cur_y) && $stable(r_win_y)))
        else $error("state moved while result was stalled");

endmodule
